// ----- rtl/tns_pkg.sv -----
package tns_pkg;

	// Default sizes
	localparam int QUEUE_SLOTS_DEF  = 4;
	localparam int MELODY_DEPTH_DEF = 64;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_MELODY_LENGTH = 1'b0;

	// Fixed field widths
	localparam int FREQ_W = 20;
	localparam int AMP_W  = 16;
	localparam int DUR_W  = 16;
	localparam int LEN_W  = 7;

	localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;

	// Mode codes
	localparam logic MODE_SONG   = 1'b0;
	localparam logic MODE_MANUAL = 1'b1;

	// Reported playback state codes
	localparam logic [1:0] PLAY_IDLE    = 2'd0;
	localparam logic [1:0] PLAY_PLAYING = 2'd1;
	localparam logic [1:0] PLAY_PAUSED  = 2'd2;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ENQUEUE = 3'd1,
		OP_PLAY    = 3'd2,
		OP_STOP    = 3'd3,
		OP_PAUSE   = 3'd4,
		OP_RESUME  = 3'd5,
		OP_LOAD    = 3'd6,
		OP_SET_AMP = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		PS_IDLE    = 3'b001,
		PS_PLAYING = 3'b010,
		PS_PAUSED  = 3'b100
	} pstate_t;

	typedef struct packed {
		op_t              operation;
		logic [FREQ_W-1:0] frequency;
		logic [AMP_W-1:0]  amplitude;
		logic [DUR_W-1:0]  duration;
		logic [5:0]        note_slot;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        play_state;
		logic              play_mode;
		logic              tone_on;
		logic [FREQ_W-1:0] current_frequency;
		logic [AMP_W-1:0]  current_amplitude;
		logic [5:0]        note_position;
		logic              accepted;
		logic [1:0]        queued;
		logic [31:0]       tick_count;
	} result_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} note_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [AMP_W-1:0]  amp;
		logic [DUR_W-1:0]  dur;
	} tone_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} ring_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

endpackage

// ----- rtl/tns_melody_mem.sv -----
module tns_melody_mem #(
	parameter int MELODY_DEPTH = tns_pkg::MELODY_DEPTH_DEF,
	parameter int PW = $clog2(MELODY_DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [PW-1:0]   wr_addr,
	input  tns_pkg::note_t  wr_note,
	input  logic [PW-1:0]   rd_addr,
	output tns_pkg::note_t  next_note,
	output tns_pkg::note_t  first_note
);
	import tns_pkg::*;

	note_t mem_q [MELODY_DEPTH];
	note_t next_q;
	note_t first_q;

	// Write the store; fetch the following note and the first note, passing a same-cycle write through
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_note;
		end
		next_q  <= (wr_en && (wr_addr == rd_addr)) ? wr_note : mem_q[rd_addr];
		first_q <= (wr_en && (wr_addr == '0)) ? wr_note : mem_q[0];
	end

	assign next_note  = next_q;
	assign first_note = first_q;

endmodule

// ----- rtl/tns_ring.sv -----
module tns_ring #(
	parameter int QUEUE_SLOTS = tns_pkg::QUEUE_SLOTS_DEF,
	parameter int QW = $clog2(QUEUE_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tns_pkg::ring_ctrl_t  ctrl,
	input  tns_pkg::tone_t       push_tone,
	output tns_pkg::tone_t       pop_tone,
	output tns_pkg::ring_stat_t  stat,
	output logic [QW-1:0]        count
);
	import tns_pkg::*;

	tone_t         slot_q [QUEUE_SLOTS];
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [QW-1:0] head_inc;
	logic [QW-1:0] tail_inc;
	logic [QW:0]   diff;

	// Step an index round the ring
	assign head_inc = (head_q == QW'(QUEUE_SLOTS - 1)) ? '0 : head_q + QW'(1);
	assign tail_inc = (tail_q == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + QW'(1);

	// Status: one slot always kept free
	assign stat.full  = (head_inc == tail_q);
	assign stat.empty = (head_q == tail_q);

	assign diff  = (head_q >= tail_q) ? {1'b0, head_q} - {1'b0, tail_q}
		: {1'b0, head_q} + (QW+1)'(QUEUE_SLOTS) - {1'b0, tail_q};
	assign count = diff[QW-1:0];

	assign pop_tone = slot_q[tail_q];

	// Advance the pointers; flush empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctrl.flush) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctrl.push && !stat.full) begin
				head_q <= head_inc;
			end
			if (ctrl.pop && !stat.empty) begin
				tail_q <= tail_inc;
			end
		end
	end

	// Hold the queued tones
	always_ff @(posedge clk) begin
		if (ctrl.push && !stat.full) begin
			slot_q[head_q] <= push_tone;
		end
	end

endmodule

// ----- rtl/tone_note_sequencer.sv -----
// The result strobe done rises in the cycle after start is taken.
// Throughput: one item every cycle; busy stays low, as every op is worked out combinationally
// between the command and the state registers.
// Reset: arst_n clears playback state, ring pointers, tick counter and melody_length;
// the melody store and ring slots hold garbage until written. Results cannot be stalled.
module tone_note_sequencer #(
	parameter int QUEUE_SLOTS  = tns_pkg::QUEUE_SLOTS_DEF,
	parameter int MELODY_DEPTH = tns_pkg::MELODY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tns_pkg::cmd_t                 cmd,
	output logic                          done,
	output tns_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tns_pkg::APB_AW-1:0]    paddr,
	input  logic [tns_pkg::APB_DW-1:0]    pwdata,
	output logic [tns_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import tns_pkg::*;

	localparam int PW = $clog2(MELODY_DEPTH);
	localparam int QW = $clog2(QUEUE_SLOTS);
	localparam int LW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

	// State registers
	pstate_t           state_q, state_d;
	logic              mode_q, mode_d;
	logic              present_q, present_d;
	logic              oe_q, oe_d;
	logic [FREQ_W-1:0] freq_q, freq_d;
	logic [AMP_W-1:0]  amp_q, amp_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [DUR_W-1:0]  tl_q, tl_d;
	logic [31:0]       tick_q, tick_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              acc_q, acc_d;
	logic              done_q;

	logic              accept;
	logic              cfg_wr;
	logic [AMP_W-1:0]  amp_sat;
	logic [DUR_W-1:0]  tl_dec;
	logic [LW-1:0]     eff_len;
	logic [PW-1:0]     pos_next;
	logic [LW-1:0]     slot_ext;
	logic              mem_we;
	note_t             next_note;
	note_t             first_note;
	ring_ctrl_t        ring_ctrl;
	ring_stat_t        ring_stat;
	tone_t             push_tone;
	tone_t             pop_tone;
	logic [QW-1:0]     ring_count;
	logic [1:0]        state_code;

	// Melody position after the current one, wrapping at the usable length
	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] pos,
		input logic [LEN_W-1:0] len);
		logic [LW-1:0] eff;
		logic [LW-1:0] inc;
		eff = (LW'(len) > LW'(MELODY_DEPTH)) ? LW'(MELODY_DEPTH) : LW'(len);
		inc = LW'(pos) + LW'(1);
		wrap_next = (inc >= eff) ? '0 : inc[PW-1:0];
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;

	// Configuration register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign len_d  = (cfg_wr && (paddr[2] == REG_MELODY_LENGTH)) ? pwdata[LEN_W-1:0] : len_q;
	assign prdata = (paddr[2] == REG_MELODY_LENGTH) ? {{(APB_DW-LEN_W){1'b0}}, len_q} : '0;

	assign amp_sat  = (cmd.amplitude > AMP_ONE) ? AMP_ONE : cmd.amplitude;
	assign tl_dec   = (tl_q != '0) ? tl_q - DUR_W'(1) : '0;
	assign eff_len  = (LW'(len_q) > LW'(MELODY_DEPTH)) ? LW'(MELODY_DEPTH) : LW'(len_q);
	assign pos_next = wrap_next(pos_q, len_q);
	assign slot_ext = LW'(cmd.note_slot);

	assign push_tone.freq = cmd.frequency;
	assign push_tone.amp  = amp_sat;
	assign push_tone.dur  = cmd.duration;

	// Work out the state after one command
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		present_d = present_q;
		oe_d      = oe_q;
		freq_d    = freq_q;
		amp_d     = amp_q;
		pos_d     = pos_q;
		tl_d      = tl_q;
		tick_d    = tick_q;
		acc_d     = 1'b0;
		ring_ctrl = '0;
		mem_we    = 1'b0;
		if (accept) begin
			unique case (cmd.operation)
				OP_TICK: begin
					tick_d = tick_q + 32'd1;
					if (state_q == PS_PLAYING) begin
						if (mode_q == MODE_SONG) begin
							if (present_q && (eff_len != '0)) begin
								tl_d = tl_dec;
								if (tl_dec == '0) begin
									pos_d  = pos_next;
									freq_d = next_note.freq;
									oe_d   = (next_note.freq != '0);
									tl_d   = next_note.dur;
								end
							end
						end else begin
							tl_d = tl_dec;
							if (tl_dec == '0) begin
								if (!ring_stat.empty) begin
									ring_ctrl.pop = 1'b1;
									amp_d  = pop_tone.amp;
									tl_d   = pop_tone.dur;
									freq_d = pop_tone.freq;
									oe_d   = (pop_tone.freq != '0);
								end else begin
									freq_d = '0;
									oe_d   = 1'b0;
								end
							end
						end
					end
				end
				OP_ENQUEUE: begin
					if (!ring_stat.full) begin
						ring_ctrl.push = 1'b1;
						if (mode_q != MODE_MANUAL) begin
							present_d = 1'b0;
							mode_d    = MODE_MANUAL;
						end
						state_d = PS_PLAYING;
						acc_d   = 1'b1;
					end
				end
				OP_PLAY: begin
					ring_ctrl.flush = 1'b1;
					present_d = 1'b1;
					amp_d     = amp_sat;
					mode_d    = MODE_SONG;
					pos_d     = '0;
					if (eff_len != '0) begin
						freq_d  = first_note.freq;
						oe_d    = (first_note.freq != '0);
						tl_d    = first_note.dur;
						state_d = PS_PLAYING;
					end else begin
						freq_d  = '0;
						oe_d    = 1'b0;
						state_d = PS_IDLE;
					end
				end
				OP_STOP: begin
					ring_ctrl.flush = 1'b1;
					present_d = 1'b0;
					tl_d      = '0;
					freq_d    = '0;
					oe_d      = 1'b0;
					state_d   = PS_IDLE;
				end
				OP_PAUSE: begin
					if (state_q == PS_PLAYING) begin
						oe_d    = 1'b0;
						state_d = PS_PAUSED;
					end
				end
				OP_RESUME: begin
					if (state_q == PS_PAUSED) begin
						if (freq_q != '0) begin
							oe_d = 1'b1;
						end
						state_d = PS_PLAYING;
					end
				end
				OP_LOAD: begin
					mem_we = (slot_ext < LW'(MELODY_DEPTH));
				end
				OP_SET_AMP: begin
					amp_d = amp_sat;
				end
				default: begin
					amp_d = amp_q;
				end
			endcase
		end
	end

	// Update state and raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= PS_IDLE;
			mode_q    <= MODE_SONG;
			present_q <= 1'b0;
			oe_q      <= 1'b0;
			freq_q    <= '0;
			amp_q     <= '0;
			pos_q     <= '0;
			tl_q      <= '0;
			tick_q    <= '0;
			len_q     <= '0;
			acc_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			present_q <= present_d;
			oe_q      <= oe_d;
			freq_q    <= freq_d;
			amp_q     <= amp_d;
			pos_q     <= pos_d;
			tl_q      <= tl_d;
			tick_q    <= tick_d;
			len_q     <= len_d;
			acc_q     <= acc_d;
			done_q    <= accept;
		end
	end

	// Melody store, fetching ahead the note that follows the next position
	tns_melody_mem #(
		.MELODY_DEPTH(MELODY_DEPTH),
		.PW(PW)
	) u_melody (
		.clk       (clk),
		.wr_en     (mem_we),
		.wr_addr   (slot_ext[PW-1:0]),
		.wr_note   ({cmd.frequency, cmd.duration}),
		.rd_addr   (wrap_next(pos_d, len_d)),
		.next_note (next_note),
		.first_note(first_note)
	);

	// Manual tone ring
	tns_ring #(
		.QUEUE_SLOTS(QUEUE_SLOTS),
		.QW(QW)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ring_ctrl),
		.push_tone(push_tone),
		.pop_tone (pop_tone),
		.stat     (ring_stat),
		.count    (ring_count)
	);

	// Map the one-hot state to its reported code
	always_comb begin
		unique case (state_q)
			PS_IDLE:    state_code = PLAY_IDLE;
			PS_PLAYING: state_code = PLAY_PLAYING;
			PS_PAUSED:  state_code = PLAY_PAUSED;
			default:    state_code = PLAY_IDLE;
		endcase
	end

	// Present the result transfer
	assign done                     = done_q;
	assign result.play_state        = state_code;
	assign result.play_mode         = mode_q;
	assign result.tone_on           = oe_q;
	assign result.current_frequency = freq_q;
	assign result.current_amplitude = amp_q;
	assign result.note_position     = 6'(pos_q);
	assign result.accepted          = acc_q;
	assign result.queued            = 2'(ring_count);
	assign result.tick_count        = tick_q;

endmodule
